/* sv/rfps_pkg.sv */
// Shared types and constants for the RF power sample parser.
// No dependencies.
package rfps_pkg;

    localparam int DBM_W     = 11;
    localparam int ABS_W     = 17;
    localparam int UNIT_W    = 8;
    localparam int WIN_W     = 13;
    localparam int CNT_W     = 4;
    localparam int DBM_ACC_W = 10;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [CNT_W-1:0] FRAME_LEN = 4'd10;
    localparam logic [CNT_W-1:0] COUNT_SAT = 4'd11;
    localparam logic [CNT_W-1:0] POS_UNIT  = 4'd9;
    localparam logic [CNT_W-1:0] POS_ABS0  = 4'd4;
    localparam logic [CNT_W-1:0] POS_ABS1  = 4'd8;
    localparam logic [CNT_W-1:0] POS_DBM1  = 4'd3;

    localparam logic signed [DBM_W-1:0] MIN_RESET = 11'sd990;
    localparam logic signed [DBM_W-1:0] MAX_RESET = -11'sd990;
    localparam logic [WIN_W-1:0]        WIN_RESET = 13'd512;

    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic signed [DBM_W-1:0] dbm;
        logic [ABS_W-1:0]        abs_val;
        logic [UNIT_W-1:0]       unit;
    } parsed_sample_t;

endpackage

/* sv/rfps_ring.sv */
// History ring storage: one write port, one registered read port.
// Depends on rfps_pkg.
module rfps_ring
    import rfps_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic signed [DBM_W-1:0] wdata,
    input  logic [AW-1:0]           raddr,
    output logic signed [DBM_W-1:0] rdata
);

    logic signed [DBM_W-1:0] mem [DEPTH];
    logic signed [DBM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rfps_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on rfps_pkg (for house style only).
module rfps_div
    import rfps_pkg::*;
#(
    parameter int N = 23,
    parameter int D = 13
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  quo_reg;
    logic [D-1:0]  rem_reg;
    logic [D-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [D:0]    trial;
    logic [D:0]    diff;

    assign trial = {rem_reg, quo_reg[N-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (!diff[D])
            begin
                rem_reg <= diff[D-1:0];
                quo_reg <= {quo_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[D-1:0];
                quo_reg <= {quo_reg[N-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/rf_power_sample_parser_stats_top.sv */
// RF power meter byte parser with running min, max and windowed mean.
// A closing sign byte that ends a good frame gives its item after the ring write, a ring
// sweep of the window entries and an SW-bit serial divide (SW = 11 + log2 depth).
// Other bytes are accepted while idle; input is held off while a sample is worked on,
// including while its item waits for the output register. Config writes taken at all times.
// Reset: async active low, then every ring entry is zeroed with input held off.
module rf_power_sample_parser_stats_top
    import rfps_pkg::*;
#(
    parameter int RING_DEPTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: window_length
    input  logic                  cfg_we,
    input  logic [WIN_W-1:0]      cfg_wdata,
    // input stream: [7:0] rx_byte
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    // output stream: [10:0] dbm_tenths, [27:11] abs_hundredths, [35:28] unit_char,
    // [46:36] min_tenths, [57:47] max_tenths, [68:58] mean_tenths, [71:69] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int WW = $clog2(RING_DEPTH + 1);
    localparam int SW = DBM_W + AW;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_WRITE, ST_SUM, ST_DIV_START, ST_DIV_WAIT, ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [WIN_W-1:0] window_reg;
    logic [WW-1:0]    win_eff;

    always_comb
    begin
        priority if (window_reg == '0)
            win_eff = WW'(1);
        else if (int'(window_reg) > RING_DEPTH)
            win_eff = WW'(RING_DEPTH);
        else
            win_eff = WW'(window_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WIN_RESET;
        else if (cfg_we)
            window_reg <= cfg_wdata;
    end

    // parser state
    logic                 in_frame_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 neg_reg;
    logic [DBM_ACC_W-1:0] dbm_acc_reg;
    logic [ABS_W-1:0]     abs_acc_reg;
    logic [UNIT_W-1:0]    unit_reg;
    logic                 ok_reg;

    logic                 accept;
    logic                 is_sign;
    logic                 is_digit;
    logic [3:0]           digit;
    logic                 frame_good;

    assign accept     = s_tvalid && s_tready;
    assign is_sign    = (s_tdata == CHAR_PLUS) || (s_tdata == CHAR_MINUS);
    assign is_digit   = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign digit      = is_digit ? 4'(s_tdata - CHAR_ZERO) : 4'd0;
    assign frame_good = in_frame_reg && (count_reg == FRAME_LEN) && ok_reg;
    assign s_tready   = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            neg_reg      <= 1'b0;
            dbm_acc_reg  <= '0;
            abs_acc_reg  <= '0;
            unit_reg     <= '0;
            ok_reg       <= 1'b1;
        end
        else if (accept)
        begin
            if (is_sign)
            begin
                // open a new frame
                in_frame_reg <= 1'b1;
                count_reg    <= CNT_W'(1);
                neg_reg      <= (s_tdata == CHAR_MINUS);
                dbm_acc_reg  <= '0;
                abs_acc_reg  <= '0;
                unit_reg     <= '0;
                ok_reg       <= 1'b1;
            end
            else if (in_frame_reg)
            begin
                if (count_reg >= CNT_W'(1) && count_reg <= POS_DBM1)
                begin
                    if (!is_digit)
                        ok_reg <= 1'b0;
                    dbm_acc_reg <= DBM_ACC_W'({dbm_acc_reg, 3'b000} + {dbm_acc_reg, 1'b0}
                                              + DBM_ACC_W'(digit));
                end
                else if (count_reg >= POS_ABS0 && count_reg <= POS_ABS1)
                begin
                    if (!is_digit)
                        ok_reg <= 1'b0;
                    abs_acc_reg <= ABS_W'({abs_acc_reg, 3'b000} + {abs_acc_reg, 1'b0}
                                          + ABS_W'(digit));
                end
                else if (count_reg == POS_UNIT)
                begin
                    unit_reg <= s_tdata;
                end
                if (count_reg < COUNT_SAT)
                    count_reg <= count_reg + 1'b1;
            end
        end
    end

    // statistics and sequencer
    parsed_sample_t          sample_reg;
    logic signed [DBM_W-1:0] min_reg;
    logic signed [DBM_W-1:0] max_reg;
    logic [AW-1:0]           widx_reg;
    logic [WW-1:0]           cnt_reg;
    logic                    pend_reg;
    logic signed [SW-1:0]    sum_reg;
    logic                    sum_neg_reg;
    logic signed [DBM_W-1:0] mean_reg;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic signed [DBM_W-1:0] ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic signed [DBM_W-1:0] ram_rdata;

    logic [AW-1:0]           widx_use;
    logic [WW-1:0]           widx_inc;
    logic                    issuing;
    logic [SW-1:0]           sum_mag;
    logic                    div_start;
    logic                    div_done;
    logic [SW-1:0]           div_q;
    logic signed [DBM_W-1:0] q_trunc;

    logic                    m_valid_reg;
    logic [OUT_DATA_W-1:0]   m_data_reg;

    assign widx_use = (WW'(widx_reg) >= win_eff) ? '0 : widx_reg;
    assign widx_inc = WW'(widx_use) + 1'b1;
    assign issuing  = (cnt_reg < win_eff);
    assign sum_mag  = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign q_trunc  = DBM_W'(div_q);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = widx_use;
        ram_wdata = sample_reg.dbm;
        ram_raddr = cnt_reg[AW-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = '0;
            end
            ST_WRITE:     ram_we = 1'b1;
            ST_IDLE, ST_SUM, ST_DIV_START, ST_DIV_WAIT, ST_DONE: ram_we = 1'b0;
            default:      ram_we = 1'b0;
        endcase
    end

    assign div_start = (state_reg == ST_DIV_START);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            min_reg     <= MIN_RESET;
            max_reg     <= MAX_RESET;
            widx_reg    <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the output item once taken, unless a new one replaces it
            if (m_valid_reg && m_tready && state_reg != ST_DONE)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    // zero one ring entry per cycle
                    if (cnt_reg[AW-1:0] == AW'(RING_DEPTH - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && is_sign && frame_good)
                        state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (sample_reg.dbm < min_reg)
                        min_reg <= sample_reg.dbm;
                    if (sample_reg.dbm > max_reg)
                        max_reg <= sample_reg.dbm;
                    widx_reg  <= (widx_inc >= win_eff) ? '0 : widx_inc[AW-1:0];
                    cnt_reg   <= '0;
                    pend_reg  <= 1'b0;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    pend_reg <= issuing;
                    if (issuing)
                        cnt_reg <= cnt_reg + 1'b1;
                    else if (!pend_reg)
                        state_reg <= ST_DIV_START;
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        cnt_reg     <= '0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_sign && frame_good)
        begin
            sample_reg.dbm     <= neg_reg ? -DBM_W'(signed'({1'b0, dbm_acc_reg}))
                                          : DBM_W'(signed'({1'b0, dbm_acc_reg}));
            sample_reg.abs_val <= abs_acc_reg;
            sample_reg.unit    <= unit_reg;
        end
        if (state_reg == ST_WRITE)
            sum_reg <= '0;
        else if (state_reg == ST_SUM && pend_reg)
            sum_reg <= sum_reg + SW'(ram_rdata);
        if (state_reg == ST_DIV_START)
            sum_neg_reg <= sum_reg[SW-1];
        if (state_reg == ST_DIV_WAIT && div_done)
            mean_reg <= sum_neg_reg ? -q_trunc : q_trunc;
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
        begin
            m_data_reg <= {3'b000, mean_reg, max_reg, min_reg, sample_reg.unit,
                           sample_reg.abs_val, sample_reg.dbm};
        end
    end

    rfps_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rfps_div #(
        .N (SW),
        .D (WW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (win_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* sv/rfps_checker.sv */
// Port-level checks on the parser's output stream, bound to the top level.
// Depends on rfps_pkg.
module rfps_checker
    import rfps_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic signed [DBM_W-1:0] dbm;
    logic signed [DBM_W-1:0] mn;
    logic signed [DBM_W-1:0] mx;
    logic signed [DBM_W-1:0] mean;

    assign dbm  = m_tdata[10:0];
    assign mn   = m_tdata[46:36];
    assign mx   = m_tdata[57:47];
    assign mean = m_tdata[68:58];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (mn <= dbm) && (dbm <= mx))
        else $error("sample outside min/max");

    a_mean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (mean >= -11'sd999) && (mean <= 11'sd999))
        else $error("mean out of range");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output item changed while stalled");

endmodule

bind rf_power_sample_parser_stats_top rfps_checker u_rfps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
